/* design/pdlc_pkg.sv */
// Shared types, constants and helpers for the Porter-Duff layer compositor.
package pdlc_pkg;

  localparam int MAX_LAYERS_DEF      = 16;
  localparam int COLOUR_CHANNELS_DEF = 3;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int NUM_CHAN            = 3;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] REG_PREMULT   = 2'd0;
  localparam logic [1:0] REG_FULLSCALE = 2'd1;
  localparam logic [1:0] REG_CHANCOUNT = 2'd2;
  localparam logic [1:0] REG_MODETABLE = 2'd3;

  localparam logic [3:0] MODE_CLEAR     = 4'd0;
  localparam logic [3:0] MODE_SRC       = 4'd1;
  localparam logic [3:0] MODE_OVER      = 4'd2;
  localparam logic [3:0] MODE_IN        = 4'd3;
  localparam logic [3:0] MODE_OUT       = 4'd4;
  localparam logic [3:0] MODE_ATOP      = 4'd5;
  localparam logic [3:0] MODE_DEST      = 4'd6;
  localparam logic [3:0] MODE_DEST_OVER = 4'd7;
  localparam logic [3:0] MODE_DEST_IN   = 4'd8;
  localparam logic [3:0] MODE_DEST_OUT  = 4'd9;
  localparam logic [3:0] MODE_DEST_ATOP = 4'd10;
  localparam logic [3:0] MODE_XOR       = 4'd11;
  localparam logic [3:0] MODE_ADD       = 4'd12;
  localparam logic [3:0] MODE_SATURATE  = 4'd13;

  typedef struct packed {
    logic        first_layer;
    logic        last_layer;
    logic [15:0] chan0;
    logic [15:0] chan1;
    logic [15:0] chan2;
    logic [15:0] layer_alpha;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_chan0;
    logic [15:0] out_chan1;
    logic [15:0] out_chan2;
    logic [15:0] out_alpha;
    logic        bad_mode;
  } out_word_t;

  typedef enum logic [2:0] {
    LOP_IDLE,
    LOP_SEED,
    LOP_MUL,
    LOP_SUM,
    LOP_OMUL
  } lane_op_t;

  typedef enum logic [2:0] {
    CK_ZERO,
    CK_CLEAR,
    CK_SRC,
    CK_DST,
    CK_WGT
  } col_kind_t;

  typedef struct packed {
    lane_op_t    op;
    col_kind_t   kind;
    logic        divide;
    logic        prem;
    logic [16:0] wa;
    logic [16:0] wb;
    logic [16:0] ar;
    logic [8:0]  clear_v;
  } lane_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] sample;
  } lane_stat_t;

  // Q16 product, rounded half up.
  function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a * b) + 34'd32768;
    return p[32:16];
  endfunction

endpackage

/* design/pdlc_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module pdlc_div #(
  parameter int DEN_W = 16,
  parameter int QUO_W = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic                   busy,
  output logic [QUO_W-1:0]       quo
);
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] low_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, low_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  // The caller guarantees the upper part of the numerator is below the divisor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rem_r  <= num[DEN_W+QUO_W-1:QUO_W];
      low_r  <= num[QUO_W-1:0];
      den_r  <= den;
      cnt_r  <= CNT_W'(QUO_W);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = low_r;
endmodule

/* design/pdlc_lane.sv */
// One colour channel lane: accumulator, blend products, divide and output scaling.
module pdlc_lane #(
  parameter int SAMPLE_BITS = pdlc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdlc_pkg::lane_cmd_t  cmd,
  input  logic                 en,
  input  logic [15:0]          xa,
  output pdlc_pkg::lane_stat_t stat
);
  import pdlc_pkg::*;

  localparam logic [24:0] SMAX = 25'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [31:0] acc_r;
  logic [40:0] pa_r;
  logic [48:0] pb_r;
  logic [48:0] prod_r;
  logic        pending_r;

  logic [23:0] xa_q;
  logic [49:0] vsum;
  logic [49:0] vrnd;
  logic [50:0] num;
  logic [50:0] lim;
  logic        div_start;
  logic        div_busy;
  logic [31:0] div_quo;
  logic [32:0] prem_t;
  logic [48:0] str_t;
  logic [24:0] samp;

  assign xa_q = {xa, 8'h00};
  assign vsum = {9'b0, pa_r} + {1'b0, pb_r};
  assign vrnd = vsum + 50'd32768;
  assign num  = {1'b0, vsum} + 51'(cmd.ar >> 1);
  assign lim  = {2'b0, cmd.ar, 32'h0};

  assign div_start = (cmd.op == LOP_SUM) && en && (cmd.kind == CK_WGT) && cmd.divide
                     && (num < lim);

  pdlc_div #(.DEN_W(17), .QUO_W(32)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num[48:0]),
    .den   (cmd.ar),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pending_r <= 1'b0;
    end else begin
      if (pending_r && !div_busy) begin
        acc_r     <= div_quo;
        pending_r <= 1'b0;
      end
      unique case (cmd.op)
        LOP_SEED: begin
          acc_r <= en ? {8'h00, xa_q} : 32'h0;
        end
        LOP_MUL: begin
          pa_r <= 41'(cmd.wa * xa_q);
          pb_r <= 49'(cmd.wb * acc_r);
        end
        LOP_SUM: begin
          if (!en) begin
            acc_r <= '0;
          end else begin
            unique case (cmd.kind)
              CK_ZERO:  acc_r <= '0;
              CK_CLEAR: acc_r <= {23'h0, cmd.clear_v};
              CK_SRC:   acc_r <= {8'h00, xa_q};
              CK_DST:   acc_r <= acc_r;
              CK_WGT: begin
                if (!cmd.divide) begin
                  acc_r <= (|vrnd[49:48]) ? 32'hFFFF_FFFF : vrnd[47:16];
                end else if (num >= lim) begin
                  acc_r <= 32'hFFFF_FFFF;
                end else begin
                  pending_r <= 1'b1;
                end
              end
              default: acc_r <= '0;
            endcase
          end
        end
        LOP_OMUL: begin
          prod_r <= 49'(acc_r * cmd.ar);
        end
        default: begin
        end
      endcase
    end
  end

  assign prem_t = {1'b0, acc_r} + 33'd128;
  assign str_t  = prod_r + 49'h80_0000;

  always_comb begin
    if (!en) begin
      samp = '0;
    end else if (cmd.prem) begin
      samp = prem_t[32:8];
    end else if (cmd.ar == 17'h0) begin
      samp = '0;
    end else begin
      samp = str_t[48:24];
    end
    if (samp > SMAX) begin
      samp = SMAX;
    end
  end

  assign stat.busy   = pending_r;
  assign stat.sample = samp[15:0];
endmodule

/* design/porter_duff_layer_compositor_core.sv */
// Porter-Duff layer compositor: alpha datapath, sequencer, channel lanes and output merge.
// A blended layer word is accepted, then passes the alpha conversion divider (skipped when
// alpha saturates), the products, weight, lane multiply and lane sum states, and then waits
// in the lane divide state while a straight-alpha blend divides by the result alpha. A base
// layer seeds the accumulators after alpha conversion. A last layer adds output scaling.
// One word is worked on at a time: input is ready only in the idle state.
// Reset (synchronous, active low) clears accumulators, layer position, config to defaults.
module porter_duff_layer_compositor_core #(
  parameter int MAX_LAYERS      = pdlc_pkg::MAX_LAYERS_DEF,
  parameter int COLOUR_CHANNELS = pdlc_pkg::COLOUR_CHANNELS_DEF,
  parameter int SAMPLE_BITS     = pdlc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdlc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pdlc_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import pdlc_pkg::*;

  localparam int POS_W = $clog2(MAX_LAYERS);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LAYERS - 1);
  localparam logic [17:0] SMAX = 18'((64'd1 << SAMPLE_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADIV, S_MUL1, S_WGT, S_LMUL, S_LSUM, S_LDIV, S_OMUL, S_EMIT
  } state_t;

  state_t      state_r, state_nxt;

  logic        prem_r;
  logic [15:0] fs_r;
  logic [1:0]  chan_count_r;
  logic [63:0] table_r;

  in_word_t    in_r;
  logic [16:0] a_src_r;
  logic [16:0] alpha_acc_r;
  logic [16:0] p_ab_r, p_bna_r, p_anb_r;
  col_kind_t   kind_r;
  logic        divide_r;
  logic [16:0] wa_r, wb_r;
  logic [8:0]  clear_r;
  logic [POS_W-1:0] pos_r;
  logic        err_r;
  logic [32:0] oal_prod_r;
  logic        out_valid_r;
  out_word_t   out_r;

  logic [15:0] fs_eff;
  logic [32:0] anum, alim;
  logic        adiv_start, adiv_busy;
  logic [16:0] adiv_quo;

  logic [3:0]  mode;
  logic [16:0] na_src, na_dst;
  logic signed [18:0] r_raw;
  logic [16:0] r_cl;
  logic [16:0] wa_c, wb_c;
  logic        div_c;
  col_kind_t   kind_c;

  lane_cmd_t   cmd;
  lane_op_t    lop;
  lane_stat_t  lane_st [NUM_CHAN];
  logic [15:0] xa_arr [NUM_CHAN];
  logic [1:0]  n_eff;
  logic        lanes_busy;
  logic [33:0] oal_rnd;
  logic [17:0] oal_sat;

  assign fs_eff = (fs_r == 16'h0) ? 16'h1 : fs_r;
  assign anum   = {1'b0, in_data.layer_alpha, 16'h0} + 33'(fs_eff >> 1);
  assign alim   = {1'b0, fs_eff, 16'h0} + 33'(fs_eff);
  assign adiv_start = (state_r == S_IDLE) && in_valid && (anum < alim);

  pdlc_div #(.DEN_W(16), .QUO_W(17)) u_adiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (adiv_start),
    .num   (anum),
    .den   (fs_eff),
    .busy  (adiv_busy),
    .quo   (adiv_quo)
  );

  assign mode   = table_r[pos_r*4 +: 4];
  assign na_src = ONE_Q16 - a_src_r;
  assign na_dst = ONE_Q16 - alpha_acc_r;

  // Result alpha and blend weights for the current layer.
  always_comb begin
    wa_c  = '0;
    wb_c  = '0;
    div_c = 1'b0;
    unique case (mode)
      MODE_CLEAR:     r_raw = 19'(na_src);
      MODE_SRC:       r_raw = 19'(a_src_r);
      MODE_OVER:      r_raw = 19'(a_src_r) + 19'(p_bna_r);
      MODE_IN:        r_raw = 19'(p_ab_r);
      MODE_OUT:       r_raw = 19'(p_anb_r);
      MODE_ATOP:      r_raw = 19'(alpha_acc_r);
      MODE_DEST:      r_raw = 19'(alpha_acc_r);
      MODE_DEST_OVER: r_raw = 19'(alpha_acc_r) + 19'(p_anb_r);
      MODE_DEST_IN:   r_raw = 19'(p_ab_r);
      MODE_DEST_OUT:  r_raw = 19'(p_bna_r);
      MODE_DEST_ATOP: r_raw = 19'(a_src_r);
      MODE_XOR:       r_raw = 19'(a_src_r) + 19'(alpha_acc_r) - {1'b0, p_ab_r, 1'b0};
      MODE_ADD:       r_raw = 19'(a_src_r) + 19'(alpha_acc_r);
      MODE_SATURATE:  r_raw = 19'(a_src_r) + 19'(alpha_acc_r);
      default:        r_raw = '0;
    endcase
    if (r_raw < 0) begin
      r_cl = '0;
    end else if (r_raw > 19'sd65536) begin
      r_cl = ONE_Q16;
    end else begin
      r_cl = r_raw[16:0];
    end

    unique case (mode)
      MODE_OVER: begin
        if (prem_r) begin
          wa_c = ONE_Q16; wb_c = na_src;
        end else begin
          wa_c = a_src_r; wb_c = p_bna_r; div_c = 1'b1;
        end
      end
      MODE_ATOP: begin
        wa_c = prem_r ? ONE_Q16 : a_src_r; wb_c = na_src;
      end
      MODE_DEST_OVER: begin
        if (prem_r) begin
          wa_c = na_dst; wb_c = ONE_Q16;
        end else begin
          wa_c = p_anb_r; wb_c = alpha_acc_r; div_c = 1'b1;
        end
      end
      MODE_DEST_ATOP: begin
        wa_c = na_dst; wb_c = prem_r ? ONE_Q16 : alpha_acc_r;
      end
      MODE_XOR: begin
        if (prem_r) begin
          wa_c = na_dst; wb_c = na_src;
        end else begin
          wa_c = p_anb_r; wb_c = p_bna_r; div_c = 1'b1;
        end
      end
      MODE_ADD: begin
        if (prem_r) begin
          wa_c = ONE_Q16; wb_c = ONE_Q16;
        end else begin
          wa_c = a_src_r; wb_c = alpha_acc_r; div_c = 1'b1;
        end
      end
      MODE_SATURATE: begin
        wa_c = (a_src_r < na_dst) ? a_src_r : na_dst;
        wb_c = prem_r ? ONE_Q16 : alpha_acc_r;
        div_c = !prem_r;
      end
      default: begin
      end
    endcase

    if (r_cl == 17'h0 || mode > MODE_SATURATE) begin
      kind_c = CK_ZERO;
    end else begin
      unique case (mode)
        MODE_CLEAR:                              kind_c = CK_CLEAR;
        MODE_SRC, MODE_IN, MODE_OUT:             kind_c = CK_SRC;
        MODE_DEST, MODE_DEST_IN, MODE_DEST_OUT:  kind_c = CK_DST;
        default:                                 kind_c = CK_WGT;
      endcase
    end
  end

  always_comb begin
    unique case (state_r)
      S_MUL1:  lop = in_r.first_layer ? LOP_SEED : LOP_IDLE;
      S_LMUL:  lop = LOP_MUL;
      S_LSUM:  lop = LOP_SUM;
      S_OMUL:  lop = LOP_OMUL;
      default: lop = LOP_IDLE;
    endcase
  end

  assign cmd.op      = lop;
  assign cmd.kind    = kind_r;
  assign cmd.divide  = divide_r;
  assign cmd.prem    = prem_r;
  assign cmd.wa      = wa_r;
  assign cmd.wb      = wb_r;
  assign cmd.ar      = alpha_acc_r;
  assign cmd.clear_v = clear_r;

  assign n_eff = (chan_count_r == 2'd0) ? 2'd1 : chan_count_r;
  assign xa_arr[0] = in_r.chan0;
  assign xa_arr[1] = in_r.chan1;
  assign xa_arr[2] = in_r.chan2;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    if (c < COLOUR_CHANNELS) begin : g_on
      pdlc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .en    (2'(c) < n_eff),
        .xa    (xa_arr[c]),
        .stat  (lane_st[c])
      );
    end else begin : g_off
      assign lane_st[c] = '0;
    end
  end

  assign lanes_busy = lane_st[0].busy | lane_st[1].busy | lane_st[2].busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = (anum < alim) ? S_ADIV : S_MUL1;
      S_ADIV: if (!adiv_busy) state_nxt = S_MUL1;
      S_MUL1: begin
        if (!in_r.first_layer) state_nxt = S_WGT;
        else state_nxt = in_r.last_layer ? S_OMUL : S_IDLE;
      end
      S_WGT:  state_nxt = S_LMUL;
      S_LMUL: state_nxt = S_LSUM;
      S_LSUM: state_nxt = S_LDIV;
      S_LDIV: if (!lanes_busy) state_nxt = in_r.last_layer ? S_OMUL : S_IDLE;
      S_OMUL: state_nxt = S_EMIT;
      S_EMIT: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign oal_rnd = {1'b0, oal_prod_r} + 34'd32768;
  assign oal_sat = (oal_rnd[33:16] > SMAX) ? SMAX : oal_rnd[33:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prem_r       <= 1'b0;
      fs_r         <= 16'd255;
      chan_count_r <= 2'd3;
      table_r      <= '0;
      alpha_acc_r  <= '0;
      pos_r        <= '0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PREMULT:   prem_r       <= cfg_data[0];
          REG_FULLSCALE: fs_r         <= cfg_data[15:0];
          REG_CHANCOUNT: chan_count_r <= cfg_data[1:0];
          REG_MODETABLE: table_r      <= cfg_data;
          default: begin
          end
        endcase
      end
      // In the emit state the result register is reloaded below instead.
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r <= in_data;
            if (anum >= alim) a_src_r <= ONE_Q16;
          end
        end
        S_ADIV: begin
          if (!adiv_busy) a_src_r <= adiv_quo;
        end
        S_MUL1: begin
          if (in_r.first_layer) begin
            alpha_acc_r <= a_src_r;
            pos_r       <= '0;
            err_r       <= 1'b0;
          end
          p_ab_r  <= qmul(a_src_r, alpha_acc_r);
          p_bna_r <= qmul(alpha_acc_r, ONE_Q16 - a_src_r);
          p_anb_r <= qmul(a_src_r, ONE_Q16 - alpha_acc_r);
        end
        S_WGT: begin
          alpha_acc_r <= r_cl;
          kind_r      <= kind_c;
          divide_r    <= div_c;
          wa_r        <= wa_c;
          wb_r        <= wb_c;
          clear_r     <= na_src[16:8];
          if (pos_r < POS_MAX) pos_r <= pos_r + POS_W'(1);
          if (mode > MODE_SATURATE) err_r <= 1'b1;
        end
        S_OMUL: begin
          oal_prod_r <= 33'(alpha_acc_r * fs_eff);
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_r.out_chan0 <= lane_st[0].sample;
            out_r.out_chan1 <= lane_st[1].sample;
            out_r.out_chan2 <= lane_st[2].sample;
            out_r.out_alpha <= oal_sat[15:0];
            out_r.bad_mode  <= err_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
